// ===== sv/weekly_alarm_table_matcher_assert.svh =====
// Assertion macros shared by the alarm matcher modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef WEEKLY_ALARM_TABLE_MATCHER_ASSERT_SVH
`define WEEKLY_ALARM_TABLE_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define WATM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WATM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/watm_pkg.sv =====
// Shared types, constants and helper functions of the weekly alarm matcher.
// Depends on nothing; imported by every module of the block.
package watm_pkg;

   localparam int ENTRIES      = 8;
   localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W        = $clog2(ENTRIES + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int MINUTES_PER_HOUR   = 60;
   localparam int PRIOR_MINUTE_RESET = 61;
   localparam int DAY_BASE_RECUR     = 8;
   localparam int DAY_BASE_ONCE      = 7;
   localparam int DAY_LAST_BIT       = 7;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_SET  = 2'd1,
      REQ_KILL = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CMD_SCAN = 2'd0,
      CMD_SET  = 2'd1,
      CMD_KILL = 2'd2
   } cmd_op_type;

   // One classified word passed from the front to the back. The minute
   // field holds the alarm minute for a set and the current minute of the
   // day for a scan.
   typedef struct packed {
      cmd_op_type  op;
      logic [2:0]  index;
      logic        enable;
      logic [10:0] minute;
      logic        recurring;
      logic [7:0]  days;
      logic        notify;
      logic [2:0]  wday;
   } cmd_type;

   typedef struct packed {
      logic [2:0] index;
      logic       last;
   } result_type;

   // Weekday test: recurring entries look at bit (8 - weekday), one-shot
   // entries at bit (7 - weekday); a position past the top bit reads zero.
   function automatic logic day_hit(logic [7:0] days, logic [2:0] wday,
                                    logic recurring);
      logic [3:0] pos;
      pos = recurring ? (4'(DAY_BASE_RECUR) - 4'(wday))
                      : (4'(DAY_BASE_ONCE) - 4'(wday));
      day_hit = (pos > 4'(DAY_LAST_BIT)) ? 1'b0 : days[pos[2:0]];
   endfunction

endpackage

// ===== sv/watm_front.sv =====
// Request front end: decodes requests, filters invalid and repeated ticks.
// Depends on watm_pkg; feeds watm_cmd_queue.
module watm_front import watm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        queue_full,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_entry_index,
   input  logic        req_enable_in,
   input  logic [10:0] req_alarm_minute,
   input  logic        req_recurring_in,
   input  logic [7:0]  req_day_mask,
   input  logic        req_notify_in,
   input  logic [11:0] req_clock_year,
   input  logic [2:0]  req_clock_weekday,
   input  logic [4:0]  req_clock_hour,
   input  logic [5:0]  req_clock_minute,
   output logic        cmd_valid,
   output cmd_type     cmd
);

   logic [5:0]   prior_minute_ff, prior_minute_in;
   logic         accept;
   logic         tick_live;
   logic [10:0]  now_of_day;
   req_kind_type kind;

   assign accept     = push && !queue_full;
   assign kind       = req_kind_type'(req_type);
   assign tick_live  = (req_clock_year != 12'd0) && (req_clock_minute != prior_minute_ff);
   assign now_of_day = 11'(req_clock_hour) * 11'(MINUTES_PER_HOUR) + 11'(req_clock_minute);

   always_comb begin
      prior_minute_in = prior_minute_ff;
      cmd_valid       = 1'b0;
      cmd.op          = CMD_SCAN;
      cmd.index       = req_entry_index;
      cmd.enable      = req_enable_in;
      cmd.minute      = req_alarm_minute;
      cmd.recurring   = req_recurring_in;
      cmd.days        = req_day_mask;
      cmd.notify      = req_notify_in;
      cmd.wday        = req_clock_weekday;
      unique case (kind)
         REQ_TICK: begin
            cmd.minute = now_of_day;
            if (accept && tick_live) begin
               cmd_valid       = 1'b1;
               prior_minute_in = req_clock_minute;
            end
         end
         REQ_SET: begin
            cmd.op    = CMD_SET;
            cmd_valid = accept;
         end
         REQ_KILL: begin
            cmd.op    = CMD_KILL;
            cmd_valid = accept;
         end
         default: begin
            cmd_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_minute_ff <= 6'(PRIOR_MINUTE_RESET);
      end else begin
         prior_minute_ff <= prior_minute_in;
      end
   end

endmodule

// ===== sv/watm_cmd_queue.sv =====
// Short command queue between the front end and the table back end.
// Depends on watm_pkg and the assertion macro header.
`include "weekly_alarm_table_matcher_assert.svh"
module watm_cmd_queue import watm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   input  cmd_type wr_cmd,
   output logic    full,
   input  logic    rd_pop,
   output cmd_type rd_cmd,
   output logic    empty
);

   cmd_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_wr, do_rd;

   assign full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign do_wr  = wr_valid && !full;
   assign do_rd  = rd_pop && !empty;
   assign rd_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   `WATM_ASSERT_IMPLY(a_cq_count_bound, clock, reset, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH), "command queue count out of range")
   `WATM_ASSERT_IMPLY(a_cq_no_overrun, clock, reset, wr_valid, !full, "command written into a full queue")
   `WATM_ASSERT_NEXT(a_cq_fill, clock, reset, do_wr && !do_rd && count_ff == QCNT_W'(QUEUE_DEPTH - 1), full, "queue did not report full after last free slot was taken")

endmodule

// ===== sv/watm_back.sv =====
// Table back end: holds the alarm entries, runs set, kill and scan
// commands, and queues the fired indexes. Depends on watm_pkg and the
// assertion macro header.
`include "weekly_alarm_table_matcher_assert.svh"
module watm_back import watm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [3:0] entries_in_use,
   input  logic       cmd_empty,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   input  logic       pop,
   output logic       empty,
   output logic [2:0] rsp_fired_index,
   output logic       rsp_last_fire
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic [10:0]       now_ff, now_in;
   logic [2:0]        wday_ff, wday_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;

   logic              enable_ff    [ENTRIES];
   logic [10:0]       minute_ff    [ENTRIES];
   logic              recurring_ff [ENTRIES];
   logic [7:0]        days_ff      [ENTRIES];
   logic              notify_ff    [ENTRIES];

   result_type        res_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] res_wr_ff, res_wr_in;
   logic [QPTR_W-1:0] res_rd_ff, res_rd_in;
   logic [QCNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic              res_full, res_push, res_pop;
   result_type        res_data;

   logic              tbl_set, tbl_kill, tbl_disarm;
   logic              idx_ok;
   logic [IDX_W-1:0]  cmd_idx;
   logic [CNT_W-1:0]  cfg_limit;
   logic              cur_hit, emit, stall, at_last;

   assign cmd_idx   = IDX_W'(cmd.index);
   assign idx_ok    = (32'(cmd.index) < ENTRIES);
   assign cfg_limit = (32'(entries_in_use) > ENTRIES) ? CNT_W'(ENTRIES)
                                                      : CNT_W'(entries_in_use);

   assign cur_hit = enable_ff[scan_idx_ff] && (minute_ff[scan_idx_ff] == now_ff) &&
                    day_hit(days_ff[scan_idx_ff], wday_ff, recurring_ff[scan_idx_ff]);
   assign emit    = cur_hit && notify_ff[scan_idx_ff];
   assign res_full = (res_cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign stall   = emit && pend_valid_ff && res_full;
   assign at_last = (CNT_W'(scan_idx_ff) == limit_ff - CNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      limit_in      = limit_ff;
      now_in        = now_ff;
      wday_in       = wday_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      cmd_pop       = 1'b0;
      tbl_set       = 1'b0;
      tbl_kill      = 1'b0;
      tbl_disarm    = 1'b0;
      res_push      = 1'b0;
      res_data.index = 3'(pend_idx_ff);
      res_data.last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  CMD_SET:  tbl_set  = idx_ok;
                  CMD_KILL: tbl_kill = idx_ok;
                  CMD_SCAN: begin
                     if (cfg_limit != '0) begin
                        state_in    = ST_SCAN;
                        scan_idx_in = '0;
                        limit_in    = cfg_limit;
                        now_in      = cmd.minute;
                        wday_in     = cmd.wday;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               tbl_disarm = cur_hit && !recurring_ff[scan_idx_ff];
               if (emit) begin
                  res_push      = pend_valid_ff;
                  pend_idx_in   = scan_idx_ff;
                  pend_valid_in = 1'b1;
               end
               if (at_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!res_full) begin
               res_push      = 1'b1;
               res_data.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result queue bookkeeping.
   assign empty           = (res_cnt_ff == '0);
   assign res_pop         = pop && !empty;
   assign rsp_fired_index = res_mem_ff[res_rd_ff].index;
   assign rsp_last_fire   = res_mem_ff[res_rd_ff].last;

   always_comb begin
      res_wr_in  = res_wr_ff;
      res_rd_in  = res_rd_ff;
      res_cnt_in = res_cnt_ff;
      if (res_push) begin
         res_wr_in = (32'(res_wr_ff) == QUEUE_DEPTH - 1) ? '0 : res_wr_ff + 1'b1;
      end
      if (res_pop) begin
         res_rd_in = (32'(res_rd_ff) == QUEUE_DEPTH - 1) ? '0 : res_rd_ff + 1'b1;
      end
      if (res_push && !res_pop) begin
         res_cnt_in = res_cnt_ff + 1'b1;
      end else if (res_pop && !res_push) begin
         res_cnt_in = res_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         res_wr_ff     <= '0;
         res_rd_ff     <= '0;
         res_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         res_wr_ff     <= res_wr_in;
         res_rd_ff     <= res_rd_in;
         res_cnt_ff    <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      limit_ff    <= limit_in;
      now_ff      <= now_in;
      wday_ff     <= wday_in;
      pend_idx_ff <= pend_idx_in;
      if (res_push) begin
         res_mem_ff[res_wr_ff] <= res_data;
      end
   end

   // Enable bits are the only table state that reset clears; the other
   // fields are always written together with the enable bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            enable_ff[i] <= 1'b0;
         end
      end else if (tbl_set) begin
         enable_ff[cmd_idx] <= cmd.enable;
      end else if (tbl_kill) begin
         enable_ff[cmd_idx] <= 1'b0;
      end else if (tbl_disarm) begin
         enable_ff[scan_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_set) begin
         minute_ff[cmd_idx]    <= cmd.minute;
         recurring_ff[cmd_idx] <= cmd.recurring;
         days_ff[cmd_idx]      <= cmd.days;
         notify_ff[cmd_idx]    <= cmd.notify;
      end
   end

   `WATM_ASSERT_IMPLY(a_bk_res_bound, clock, reset, 1'b1, res_cnt_ff <= QCNT_W'(QUEUE_DEPTH), "result queue count out of range")
   `WATM_ASSERT_IMPLY(a_bk_scan_range, clock, reset, state_ff == ST_SCAN, CNT_W'(scan_idx_ff) < limit_ff, "scan index beyond scan limit")
   `WATM_ASSERT_IMPLY(a_bk_idle_clean, clock, reset, state_ff == ST_IDLE, !pend_valid_ff, "held result left over after a scan")
   `WATM_ASSERT_NEXT(a_bk_flush_done, clock, reset, state_ff == ST_FLUSH && !(pend_valid_ff && res_full), state_ff == ST_IDLE, "flush did not return to idle")

endmodule

// ===== sv/weekly_alarm_table_matcher.sv =====
// Top level of the weekly alarm table matcher: front end, command queue,
// table back end and the scan-length register. Depends on watm_pkg,
// watm_front, watm_cmd_queue and watm_back.
//
//   Channel   Handshake            Carries
//   req       push / full          one request word (tick, set or kill)
//   rsp       pop / empty          one fired entry index with its last marker
//   csr       valid / ready        the entries_in_use scan length
//
// A set or kill word is carried out by the back end once it reaches the
// head of the command queue. A tick that passes the year and repeated-minute
// filter is issued, then scans each entry in turn up to the smaller of
// entries_in_use and the table depth, and ends with a closing step. With a
// scan length of zero it is only issued. A tick that is filtered out
// never reaches the back end. The scan stalls when a notifying entry finds
// the two-word result queue full while a word is already held back for its
// last marker, and the closing step waits for room in that queue. Reset is
// synchronous and clears every enable bit at once; no clearing pass follows
// it. The csr channel is always ready.
module weekly_alarm_table_matcher import watm_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_entry_index,
   input  logic        req_enable_in,
   input  logic [10:0] req_alarm_minute,
   input  logic        req_recurring_in,
   input  logic [7:0]  req_day_mask,
   input  logic        req_notify_in,
   input  logic [11:0] req_clock_year,
   input  logic [2:0]  req_clock_weekday,
   input  logic [4:0]  req_clock_hour,
   input  logic [5:0]  req_clock_minute,

   input  logic        pop,
   output logic        empty,
   output logic [2:0]  rsp_fired_index,
   output logic        rsp_last_fire,

   input  logic        valid,
   output logic        ready,
   input  logic [3:0]  csr_entries_in_use
);

   logic [3:0] entries_reg_ff, entries_reg_in;

   logic       front_valid;
   cmd_type    front_cmd;
   logic       q_full, q_empty, q_pop;
   cmd_type    q_cmd;

   // The configuration register is always writable; the user must write it
   // only while the block is idle, which the block does not enforce.
   assign ready = 1'b1;
   assign full  = q_full;

   always_comb begin
      entries_reg_in = entries_reg_ff;
      if (valid && ready) begin
         entries_reg_in = csr_entries_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_reg_ff <= '0;
      end else begin
         entries_reg_ff <= entries_reg_in;
      end
   end

   // The front end decodes each accepted word and drops ticks that carry
   // no valid clock or repeat the last minute seen.
   watm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .queue_full        (q_full),
      .req_type          (req_type),
      .req_entry_index   (req_entry_index),
      .req_enable_in     (req_enable_in),
      .req_alarm_minute  (req_alarm_minute),
      .req_recurring_in  (req_recurring_in),
      .req_day_mask      (req_day_mask),
      .req_notify_in     (req_notify_in),
      .req_clock_year    (req_clock_year),
      .req_clock_weekday (req_clock_weekday),
      .req_clock_hour    (req_clock_hour),
      .req_clock_minute  (req_clock_minute),
      .cmd_valid         (front_valid),
      .cmd               (front_cmd)
   );

   // The queue lets the front keep accepting while a scan is in progress.
   watm_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_cmd   (front_cmd),
      .full     (q_full),
      .rd_pop   (q_pop),
      .rd_cmd   (q_cmd),
      .empty    (q_empty)
   );

   // The back end owns the table, walking it one entry per cycle unless stalled.
   watm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .entries_in_use  (entries_reg_ff),
      .cmd_empty       (q_empty),
      .cmd             (q_cmd),
      .cmd_pop         (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_fired_index (rsp_fired_index),
      .rsp_last_fire   (rsp_last_fire)
   );

endmodule
